### sv/framed_command_receiver_with_timeout_core_macros.svh
// Assertion helpers for the frame receiver.
// Both forms sample on clk and are disabled while rst_n is low.
`ifndef FRAMED_COMMAND_RECEIVER_WITH_TIMEOUT_CORE_MACROS_SVH
`define FRAMED_COMMAND_RECEIVER_WITH_TIMEOUT_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent
`define FCR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Consequent must hold in the cycle after the antecedent
`define FCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`else

`define FCR_ASSERT_NOW(label, ante, cons)
`define FCR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### sv/fcr_pkg.sv
package fcr_pkg;

  // Frame geometry
  localparam int PAYLOAD_BYTES = 8;
  localparam int FPOS_W        = $clog2(PAYLOAD_BYTES + 3);
  localparam int BUF_IDX_W     = $clog2(PAYLOAD_BYTES);

  localparam logic [FPOS_W-1:0] POS_HUNT    = FPOS_W'(0);
  localparam logic [FPOS_W-1:0] POS_FIRST   = FPOS_W'(1);
  localparam logic [FPOS_W-1:0] POS_LAST    = FPOS_W'(PAYLOAD_BYTES);
  localparam logic [FPOS_W-1:0] POS_CHECK   = FPOS_W'(PAYLOAD_BYTES + 1);
  localparam logic [FPOS_W-1:0] POS_TRAILER = FPOS_W'(PAYLOAD_BYTES + 2);

  localparam logic [7:0] HEADER_BYTE  = 8'd255;
  localparam logic [7:0] TRAILER_BYTE = 8'd240;

  // Counter and configuration widths
  localparam int TICK_W     = 32;
  localparam int TIMEOUT_W  = 32;
  localparam int DEADBAND_W = 7;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = TIMEOUT_W'(250);
  localparam logic [DEADBAND_W-1:0] DEADBAND_RST = DEADBAND_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT  = 1'b0,
    CFG_DEADBAND = 1'b1
  } cfg_idx_t;

  // Queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // One classified item as it travels through the queue
  typedef struct packed {
    logic       is_tick;
    logic       is_header;
    logic       is_trailer;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

### sv/fcr_front.sv
module fcr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_action,
  input  logic [7:0]           in_rx_byte,
  input  fcr_pkg::fifo_status_t fifo_st,
  output logic                 push,
  output fcr_pkg::item_t       push_item
);
  import fcr_pkg::*;

  logic  stage_valid_r, stage_valid_nxt;
  item_t stage_item_r;
  item_t item_nxt;
  logic  take;

  // Hold the input while the staged item cannot enter the queue
  assign in_stall = stage_valid_r & fifo_st.full;
  assign take     = in_valid & ~in_stall;
  assign push     = stage_valid_r & ~fifo_st.full;
  assign push_item = stage_item_r;

  // Classify the incoming item
  always_comb begin
    item_nxt.is_tick    = in_action;
    item_nxt.is_header  = ~in_action & (in_rx_byte == HEADER_BYTE);
    item_nxt.is_trailer = ~in_action & (in_rx_byte == TRAILER_BYTE);
    item_nxt.data       = in_rx_byte;
  end

  assign stage_valid_nxt = take | (stage_valid_r & fifo_st.full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  // Load the stage on each transfer
  always_ff @(posedge clk) begin
    if (take) begin
      stage_item_r <= item_nxt;
    end
  end

endmodule

### sv/fcr_fifo.sv
module fcr_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  fcr_pkg::item_t        push_item,
  input  logic                  pop,
  output fcr_pkg::item_t        pop_item,
  output fcr_pkg::fifo_status_t fifo_st
);
  import fcr_pkg::*;

  item_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;

  assign fifo_st.full  = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign fifo_st.empty = (count_r == '0);
  assign pop_item      = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### sv/fcr_back.sv
module fcr_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fcr_pkg::fifo_status_t            fifo_st,
  input  fcr_pkg::item_t                   pop_item,
  output logic                             pop,
  input  logic [fcr_pkg::TIMEOUT_W-1:0]    timeout_r,
  input  logic [fcr_pkg::DEADBAND_W-1:0]   deadband_r,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_link_up,
  output logic                             out_frame_accepted,
  output logic [7:0]                       out_left_cmd,
  output logic [7:0]                       out_right_cmd,
  output logic                             out_pulley_on,
  output logic                             out_button_y,
  output logic                             out_button_x,
  output logic                             out_button_b,
  output logic                             out_button_a
);
  import fcr_pkg::*;

  localparam logic [15:0] SCALE_MUL    = 16'd58983;  // 0.9 in Q16, rounded up
  localparam logic [7:0]  DRIVE_SPAN   = 8'd180;
  localparam logic [7:0]  DRIVE_CENTER = 8'd90;

  // Stick scaling by 180/200, truncating
  function automatic logic [7:0] scale_stick(input logic [7:0] v);
    logic [23:0] prod;
    prod = v * SCALE_MUL;
    return prod[23:16];
  endfunction

  logic [FPOS_W-1:0] pos_r, pos_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [7:0]        buf_r [PAYLOAD_BYTES];
  logic [7:0]        committed_r [PAYLOAD_BYTES];
  logic [7:0]        committed_nxt [PAYLOAD_BYTES];
  logic              link_r, link_nxt;
  logic [TICK_W-1:0] elapsed_r, elapsed_nxt;
  logic              accepted_r, commit;
  logic [7:0]        left_r, right_r;
  logic [4:0]        flags_r;
  logic              out_valid_r;
  logic              buf_we;
  logic [BUF_IDX_W-1:0] buf_idx;
  logic [FPOS_W-1:0] pos_off;
  logic [7:0]        left_raw, turn, right_raw, off, left_nxt, right_nxt;
  logic [4:0]        flags_nxt;

  // Take an item whenever the result register is free or being drained
  assign pop       = ~fifo_st.empty & (~out_valid_r | ~out_stall);
  assign out_valid = out_valid_r;

  assign pos_off = pos_r - POS_FIRST;
  assign buf_idx = pos_off[BUF_IDX_W-1:0];

  // Framing machine
  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    buf_we  = 1'b0;
    commit  = 1'b0;
    if (!pop_item.is_tick) begin
      if (pos_r == POS_HUNT) begin
        if (pop_item.is_header) begin
          pos_nxt = POS_FIRST;
        end
      end else if (pos_r <= POS_LAST) begin
        buf_we  = 1'b1;
        sum_nxt = sum_r + pop_item.data;
        pos_nxt = pos_r + 1'b1;
      end else if (pos_r == POS_CHECK) begin
        pos_nxt = (pop_item.data == sum_r) ? POS_TRAILER : POS_HUNT;
        sum_nxt = '0;
      end else begin
        commit  = pop_item.is_trailer;
        pos_nxt = POS_HUNT;
      end
    end
  end

  // Tick counter and link flag
  always_comb begin
    elapsed_nxt = elapsed_r;
    if (commit) begin
      elapsed_nxt = '0;
    end else if (pop_item.is_tick && (elapsed_r != '1)) begin
      elapsed_nxt = elapsed_r + 1'b1;
    end
    link_nxt = (link_r | commit) & ~(elapsed_nxt >= TICK_W'(timeout_r));
  end

  always_comb begin
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      committed_nxt[i] = commit ? buf_r[i] : committed_r[i];
    end
  end

  // Drive commands and button flags from the committed payload
  always_comb begin
    left_raw  = scale_stick(committed_nxt[3]);
    turn      = scale_stick(committed_nxt[4]);
    right_raw = DRIVE_SPAN - left_raw;
    off       = (turn >= DRIVE_CENTER) ? (turn - DRIVE_CENTER) : (DRIVE_CENTER - turn);
    if (off > {1'b0, deadband_r}) begin
      left_nxt  = turn;
      right_nxt = turn;
    end else begin
      left_nxt  = left_raw;
      right_nxt = right_raw;
    end
    flags_nxt = {committed_nxt[1][3], committed_nxt[0][3:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_HUNT;
      sum_r       <= '0;
      link_r      <= 1'b0;
      elapsed_r   <= '0;
      accepted_r  <= 1'b0;
      left_r      <= '0;
      right_r     <= '0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
        committed_r[i] <= '0;
      end
    end else begin
      out_valid_r <= pop | (out_valid_r & out_stall);
      if (pop) begin
        pos_r      <= pos_nxt;
        sum_r      <= sum_nxt;
        link_r     <= link_nxt;
        elapsed_r  <= elapsed_nxt;
        accepted_r <= commit;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
          committed_r[i] <= committed_nxt[i];
        end
        if (link_nxt) begin
          left_r  <= left_nxt;
          right_r <= right_nxt;
          flags_r <= flags_nxt;
        end
      end
    end
  end

  // Collect payload bytes
  always_ff @(posedge clk) begin
    if (pop && buf_we) begin
      buf_r[buf_idx] <= pop_item.data;
    end
  end

  // State registers double as the result register
  assign out_link_up        = link_r;
  assign out_frame_accepted = accepted_r;
  assign out_left_cmd       = left_r;
  assign out_right_cmd      = right_r;
  assign out_pulley_on      = flags_r[4];
  assign out_button_y       = flags_r[3];
  assign out_button_x       = flags_r[2];
  assign out_button_b       = flags_r[1];
  assign out_button_a       = flags_r[0];

endmodule

### sv/framed_command_receiver_with_timeout_core.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_stall    action, rx_byte
// out_      output     out_valid/out_stall  link_up, frame_accepted, left_cmd,
//                                           right_cmd, pulley_on, button_y/x/b/a
// cfg_      input      cfg_wr_en            cfg_index, cfg_wdata
//
// One item per cycle sustained while out_stall is low; a result is presented after its input transfer
// passes the front stage register, the queue entry and the back state/result register, in that order.
// The back state updates once per popped item, so it sets the item rate.
// Reset is synchronous on rst_n; registers return to timeout 250, deadband 5.
// A stalled result holds the back; the queue absorbs the front until it fills.
`include "framed_command_receiver_with_timeout_core_macros.svh"

module framed_command_receiver_with_timeout_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_action,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_link_up,
  output logic                            out_frame_accepted,
  output logic [7:0]                      out_left_cmd,
  output logic [7:0]                      out_right_cmd,
  output logic                            out_pulley_on,
  output logic                            out_button_y,
  output logic                            out_button_x,
  output logic                            out_button_b,
  output logic                            out_button_a,
  input  logic                            cfg_wr_en,
  input  logic [fcr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fcr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import fcr_pkg::*;

  logic [TIMEOUT_W-1:0]  timeout_r;
  logic [DEADBAND_W-1:0] deadband_r;
  fifo_status_t          fifo_st;
  item_t                 push_item, pop_item;
  logic                  fifo_push, fifo_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= TIMEOUT_RST;
      deadband_r <= DEADBAND_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TIMEOUT:  timeout_r  <= cfg_wdata[TIMEOUT_W-1:0];
        CFG_DEADBAND: deadband_r <= cfg_wdata[DEADBAND_W-1:0];
        default: ;
      endcase
    end
  end

  fcr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .in_rx_byte(in_rx_byte),
    .fifo_st   (fifo_st),
    .push      (fifo_push),
    .push_item (push_item)
  );

  fcr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fifo_push),
    .push_item(push_item),
    .pop      (fifo_pop),
    .pop_item (pop_item),
    .fifo_st  (fifo_st)
  );

  fcr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .fifo_st           (fifo_st),
    .pop_item          (pop_item),
    .pop               (fifo_pop),
    .timeout_r         (timeout_r),
    .deadband_r        (deadband_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_link_up       (out_link_up),
    .out_frame_accepted(out_frame_accepted),
    .out_left_cmd      (out_left_cmd),
    .out_right_cmd     (out_right_cmd),
    .out_pulley_on     (out_pulley_on),
    .out_button_y      (out_button_y),
    .out_button_x      (out_button_x),
    .out_button_b      (out_button_b),
    .out_button_a      (out_button_a)
  );

  // Every item taken by the back yields a result in the next cycle
  `FCR_ASSERT_NEXT(a_pop_gives_result, fifo_pop, out_valid)
  // A full queue takes no push
  `FCR_ASSERT_NOW(a_full_blocks_push, fifo_st.full, !fifo_push)
  // A completed frame raises the link unless the timeout is zero
  `FCR_ASSERT_NOW(a_accept_raises_link, out_valid && out_frame_accepted && (timeout_r != '0), out_link_up)

endmodule

### verif/tb.sv
module tb;
  import fcr_pkg::*;

  localparam int STICK_MUL    = 180;
  localparam int STICK_DIV    = 200;
  localparam int STICK_CENTER = 90;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic       is_tick;
    logic [7:0] data;
  } rx_item_t;

  typedef struct packed {
    logic       link_up;
    logic       frame_accepted;
    logic [7:0] left_cmd;
    logic [7:0] right_cmd;
    logic       pulley_on;
    logic       button_y;
    logic       button_x;
    logic       button_b;
    logic       button_a;
  } cmd_status_t;

  typedef enum int {FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_TRAILER} frame_kind_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_action = 1'b0;
  logic [7:0]            in_rx_byte = 8'h00;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_link_up;
  logic                  out_frame_accepted;
  logic [7:0]            out_left_cmd;
  logic [7:0]            out_right_cmd;
  logic                  out_pulley_on;
  logic                  out_button_y;
  logic                  out_button_x;
  logic                  out_button_b;
  logic                  out_button_a;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  framed_command_receiver_with_timeout_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_link_up        (out_link_up),
    .out_frame_accepted (out_frame_accepted),
    .out_left_cmd       (out_left_cmd),
    .out_right_cmd      (out_right_cmd),
    .out_pulley_on      (out_pulley_on),
    .out_button_y       (out_button_y),
    .out_button_x       (out_button_x),
    .out_button_b       (out_button_b),
    .out_button_a       (out_button_a),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // Stimulus and expectation stores
  rx_item_t    rx_pending[$];
  cmd_status_t status_expected[$];
  int          queued_total = 0;
  int          mismatch_count = 0;
  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;

  // Receiver shadow state
  logic [TIMEOUT_W-1:0]  timeout_limit;
  logic [DEADBAND_W-1:0] deadband;
  logic [FPOS_W-1:0]     frame_pos;
  logic [7:0]            run_sum;
  logic [7:0]            frame_buf [PAYLOAD_BYTES];
  logic [7:0]            cmd_bytes [PAYLOAD_BYTES];
  logic                  link_ok;
  logic [TICK_W-1:0]     tick_count;
  logic [7:0]            held_left;
  logic [7:0]            held_right;
  logic [4:0]            held_flags;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void reset_receiver_shadow();
    timeout_limit = TIMEOUT_RST;
    deadband      = DEADBAND_RST;
    frame_pos     = POS_HUNT;
    run_sum       = 8'h00;
    link_ok       = 1'b0;
    tick_count    = '0;
    held_left     = 8'h00;
    held_right    = 8'h00;
    held_flags    = 5'h00;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      frame_buf[i] = 8'h00;
      cmd_bytes[i] = 8'h00;
    end
  endfunction

  function automatic logic [7:0] scale_stick(logic [7:0] v);
    return 8'((int'(v) * STICK_MUL) / STICK_DIV);
  endfunction

  // Advance the framer and link timer by one byte or tick; return the status it yields
  function automatic cmd_status_t advance_receiver(logic is_tick, logic [7:0] b);
    cmd_status_t r;
    logic        took;
    logic [7:0]  left;
    logic [7:0]  turn;
    logic [7:0]  right;
    int          off;
    took = 1'b0;
    if (!is_tick) begin
      if (frame_pos == POS_HUNT) begin
        if (b == HEADER_BYTE) frame_pos = POS_FIRST;
      end else if (frame_pos <= POS_LAST) begin
        frame_buf[BUF_IDX_W'(frame_pos - POS_FIRST)] = b;
        run_sum = run_sum + b;
        frame_pos = frame_pos + 1'b1;
      end else if (frame_pos == POS_CHECK) begin
        frame_pos = (b == run_sum) ? POS_TRAILER : POS_HUNT;
        run_sum = 8'h00;
      end else begin
        if (b == TRAILER_BYTE) begin
          cmd_bytes  = frame_buf;
          link_ok    = 1'b1;
          tick_count = '0;
          took       = 1'b1;
        end
        frame_pos = POS_HUNT;
      end
    end else if (tick_count != '1) begin
      tick_count = tick_count + 1'b1;
    end

    // Drop the link once the elapsed count reaches the limit
    if (link_ok && tick_count >= timeout_limit) link_ok = 1'b0;

    // Refresh held outputs only while the link is up
    if (link_ok) begin
      left  = scale_stick(cmd_bytes[3]);
      turn  = scale_stick(cmd_bytes[4]);
      right = 8'(STICK_MUL - int'(left));
      off   = (int'(turn) >= STICK_CENTER) ? int'(turn) - STICK_CENTER
                                           : STICK_CENTER - int'(turn);
      if (off > int'(deadband)) begin
        left  = turn;
        right = turn;
      end
      held_left  = left;
      held_right = right;
      held_flags = {cmd_bytes[1][3], cmd_bytes[0][3:0]};
    end

    r.link_up        = link_ok;
    r.frame_accepted = took;
    r.left_cmd       = held_left;
    r.right_cmd      = held_right;
    r.pulley_on      = held_flags[4];
    r.button_y       = held_flags[3];
    r.button_x       = held_flags[2];
    r.button_b       = held_flags[1];
    r.button_a       = held_flags[0];
    return r;
  endfunction

  // Input driver: hold a stalled transfer, otherwise load the next item or idle
  always @(posedge clk) begin : rx_driver
    bit       load;
    rx_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        status_expected.push_back(advance_receiver(in_action, in_rx_byte));
      end
      load = 1'b0;
      if (!in_valid || !in_stall) begin
        load = rx_pending.size() != 0 && $urandom_range(0, 99) >= send_gap_pct;
        if (load) begin
          nxt = rx_pending.pop_front();
          in_action  <= nxt.is_tick;
          in_rx_byte <= nxt.data;
        end
        in_valid <= load;
      end
    end
  end

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      if (mismatch_count < 10) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
      mismatch_count++;
    end
  endtask

  // Result monitor: compare each transfer with the oldest expectation
  always @(posedge clk) begin : status_monitor
    cmd_status_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (status_expected.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%0t: result transfer with nothing expected", $time);
          end
          mismatch_count++;
        end else begin
          want = status_expected.pop_front();
          check_field("link_up", 8'(out_link_up), 8'(want.link_up));
          check_field("frame_accepted", 8'(out_frame_accepted), 8'(want.frame_accepted));
          check_field("left_cmd", out_left_cmd, want.left_cmd);
          check_field("right_cmd", out_right_cmd, want.right_cmd);
          check_field("pulley_on", 8'(out_pulley_on), 8'(want.pulley_on));
          check_field("button_y", 8'(out_button_y), 8'(want.button_y));
          check_field("button_x", 8'(out_button_x), 8'(want.button_x));
          check_field("button_b", 8'(out_button_b), 8'(want.button_b));
          check_field("button_a", 8'(out_button_a), 8'(want.button_a));
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic push_item(logic is_tick, logic [7:0] data);
    rx_item_t it;
    it.is_tick = is_tick;
    it.data    = data;
    rx_pending.push_back(it);
    queued_total++;
  endtask

  // Queue one frame; the broken kinds corrupt the checksum or the trailer
  task automatic push_frame(logic [7:0] payload [PAYLOAD_BYTES], frame_kind_t kind);
    logic [7:0] sum;
    logic [7:0] tail;
    sum = 8'h00;
    push_item(1'b0, HEADER_BYTE);
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      push_item(1'b0, payload[i]);
      sum = sum + payload[i];
    end
    if (kind == FRAME_BAD_SUM) sum = sum ^ (8'h01 << $urandom_range(0, 7));
    push_item(1'b0, sum);
    tail = TRAILER_BYTE;
    if (kind == FRAME_BAD_TRAILER) begin
      tail = 8'($urandom_range(0, 255));
      if (tail == TRAILER_BYTE) tail = 8'h00;
    end
    push_item(1'b0, tail);
  endtask

  task automatic random_payload(output logic [7:0] payload [PAYLOAD_BYTES]);
    for (int i = 0; i < PAYLOAD_BYTES; i++) payload[i] = 8'($urandom_range(0, 255));
    // Keep the turn stick near center half the time to hit the deadband edges
    if ($urandom_range(0, 1) == 0) payload[4] = 8'($urandom_range(88, 112));
  endtask

  // Mostly well-formed frames with random content, mixed with ticks and noise
  task automatic random_traffic(int n_items, int burst_max);
    int          start;
    int          pick;
    int          n;
    logic [7:0]  payload [PAYLOAD_BYTES];
    start = queued_total;
    while (queued_total - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        random_payload(payload);
        push_frame(payload, FRAME_GOOD);
      end else if (pick < 60) begin
        random_payload(payload);
        push_frame(payload, ($urandom_range(0, 1) == 0) ? FRAME_BAD_SUM : FRAME_BAD_TRAILER);
      end else if (pick < 85) begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, burst_max) : $urandom_range(1, 8);
        repeat (n) push_item(1'b1, 8'($urandom_range(0, 255)));
      end else if (pick < 93) begin
        repeat ($urandom_range(1, 4)) push_item(1'b0, 8'($urandom_range(0, 255)));
      end else begin
        // Truncated frame: header and a few payload bytes, then whatever follows
        push_item(1'b0, HEADER_BYTE);
        repeat ($urandom_range(0, PAYLOAD_BYTES)) push_item(1'b0, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Hold off until every queued item is sent and every result has arrived
  task automatic wait_drained();
    do @(negedge clk);
    while (rx_pending.size() != 0 || in_valid || status_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_TIMEOUT) timeout_limit = value[TIMEOUT_W-1:0];
    else deadband = value[DEADBAND_W-1:0];
    @(negedge clk);
  endtask

  task automatic run_phase(logic [CFG_DATA_W-1:0] timeout, logic [CFG_DATA_W-1:0] band,
                           int gap_pct, int stall_pct, int n_items, int burst_max);
    write_reg(CFG_TIMEOUT, timeout);
    write_reg(CFG_DEADBAND, band);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    random_traffic(n_items, burst_max);
    wait_drained();
  endtask

  // Main sequence
  initial begin
    logic [7:0] payload [PAYLOAD_BYTES];
    reset_receiver_shadow();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: ignored byte on a tick, extreme-valued good frame, bad checksum
    push_item(1'b1, HEADER_BYTE);
    payload = '{8'h0F, 8'h08, 8'h00, 8'hFF, 8'd100, 8'h00, 8'h00, 8'h00};
    push_frame(payload, FRAME_GOOD);
    payload = '{8'hF0, 8'hF7, 8'hAA, 8'h00, 8'h00, 8'h55, 8'h80, 8'h7F};
    push_frame(payload, FRAME_BAD_SUM);
    wait_drained();

    // Register settings, idle patterns and tick burst lengths per phase
    run_phase(32'd20, 32'd5, 0, 0, 300, 30);
    run_phase(32'd1, 32'd0, 51, 0, 300, 4);
    run_phase(32'd0, 32'd127, 0, 51, 200, 4);
    run_phase(32'd250, 32'd90, 28, 28, 400, 300);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FF8A, 28, 28, 200, 300);
    run_phase(32'd7, 32'd5, 0, 0, 200, 12);

    if (mismatch_count == 0 && status_expected.size() == 0) begin
      $display("framed_command_receiver_with_timeout_core: match");
    end else begin
      $display("framed_command_receiver_with_timeout_core: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("framed_command_receiver_with_timeout_core: mismatch");
    $finish;
  end

endmodule
